// ===== rtl/mbmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbmd_pkg: shared types and constants of the multi-button debouncer
// Action codes, register indexes, history patterns and the control and
// status bundles between the top level and the per-button cells.
// ----------------------------------------------------------------------------
package mbmd_pkg;

   // Request actions
   typedef enum logic [1:0] {
      ACT_TICK         = 2'd0,
      ACT_TAKE_PRESS   = 2'd1,
      ACT_TAKE_RELEASE = 2'd2,
      ACT_READ_STATE   = 2'd3
   } action_type;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_HISTORY_MASK     = 2'd0;
   localparam logic [1:0] REG_TICKS_PER_SAMPLE = 2'd1;
   localparam logic [1:0] REG_ACTIVE_LOW_MASK  = 2'd2;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values
   localparam logic [7:0] HISTORY_MASK_RST     = 8'hC7;
   localparam logic [7:0] TICKS_PER_SAMPLE_RST = 8'h01;
   localparam logic [7:0] ACTIVE_LOW_MASK_RST  = 8'hFF;

   // History patterns
   localparam logic [7:0] PRESS_PATTERN   = 8'b0000_0111;
   localparam logic [7:0] RELEASE_PATTERN = 8'b1100_0000;
   localparam logic [7:0] HIST_FULL       = 8'hFF;
   localparam logic [7:0] HIST_EMPTY      = 8'h00;

   localparam logic [15:0] HOLD_MAX = 16'hFFFF;

   // Buttons with a pin bit and a polarity bit
   localparam int unsigned PIN_COUNT = 8;

   // Per-button control from the top level
   typedef struct packed {
      logic sample;
      logic level;
      logic clr_press;
      logic clr_release;
   } btn_ctl_type;

   // Per-button status to the top level
   typedef struct packed {
      logic        down;
      logic        press_pending;
      logic        release_pending;
      logic [15:0] hold_count;
   } btn_stat_type;

endpackage

// ===== rtl/mbmd_button.sv =====
// ----------------------------------------------------------------------------
// mbmd_button: debounce state of one button
// Shifts a sample into the history, matches the masked history against the
// press and release patterns, keeps the down state, sticky flags and the
// saturating held counter.
// ----------------------------------------------------------------------------
module mbmd_button (
   input  logic                   clock,
   input  logic                   reset,
   input  mbmd_pkg::btn_ctl_type  ctl,
   input  logic [7:0]             history_mask,
   output mbmd_pkg::btn_stat_type stat
);

   logic [7:0]  history_ff, history_in;
   logic        down_ff, down_in;
   logic        press_ff, press_in;
   logic        release_ff, release_in;
   logic [15:0] hold_ff, hold_in;

   logic [7:0]  shifted;
   logic [7:0]  seen;
   logic        press_hit;
   logic        release_hit;
   logic [15:0] hold_base;

   // Match the masked history and work out the next state
   always_comb begin
      shifted     = {history_ff[6:0], ctl.level};
      seen        = shifted & history_mask;
      press_hit   = (seen == mbmd_pkg::PRESS_PATTERN);
      release_hit = !press_hit && (seen == mbmd_pkg::RELEASE_PATTERN);

      history_in = history_ff;
      down_in    = down_ff;
      hold_in    = hold_ff;
      hold_base  = hold_ff;

      if (ctl.sample) begin
         if (press_hit) begin
            history_in = mbmd_pkg::HIST_FULL;
            down_in    = 1'b1;
            hold_base  = '0;
         end else if (release_hit) begin
            history_in = mbmd_pkg::HIST_EMPTY;
            down_in    = 1'b0;
            hold_base  = '0;
         end else begin
            history_in = shifted;
         end
         // count the sample while down, saturating
         if (down_in && (hold_base != mbmd_pkg::HOLD_MAX)) begin
            hold_in = hold_base + 16'd1;
         end else begin
            hold_in = hold_base;
         end
      end
   end

   // Set sticky flags on an edge, drop them when taken
   always_comb begin
      press_in   = press_ff;
      release_in = release_ff;
      if (ctl.sample && press_hit) begin
         press_in = 1'b1;
      end else if (ctl.clr_press) begin
         press_in = 1'b0;
      end
      if (ctl.sample && release_hit) begin
         release_in = 1'b1;
      end else if (ctl.clr_release) begin
         release_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         down_ff    <= 1'b0;
         press_ff   <= 1'b0;
         release_ff <= 1'b0;
         hold_ff    <= '0;
      end else begin
         history_ff <= history_in;
         down_ff    <= down_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         hold_ff    <= hold_in;
      end
   end

   always_comb begin
      stat.down            = down_ff;
      stat.press_pending   = press_ff;
      stat.release_pending = release_ff;
      stat.hold_count      = hold_ff;
   end

endmodule

// ===== rtl/multi_button_mask_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_button_mask_debouncer: shift-register debouncer for several buttons
// Tick requests sample all buttons through a prescaler; query requests take
// the press or release flag of one button or read its state and held count.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request channel (valid/ready). req_action selects a tick or a
//            query; req_pin_levels is used by ticks, req_button by queries.
//   rsp_*  : one response per query, none for a tick (valid/ready).
//   csr_*  : APB-style register port, registers at byte 0, 4 and 8, always
//            ready; write only while no request is in flight.
// Timing:
//   A request is taken into an input register; when it leaves that register,
//   a tick samples all button cells at once and a query loads the response register.
//   One request per cycle is sustained unless a query waits on the response
//   register; the input register drains into the response register in every
//   cycle that the response side can take.
// Stall:
//   While a response waits, ticks keep flowing; a query stays in the input
//   register until the response register frees up, and ready stays low.
// Reset:
//   Clears all button state, the prescaler and the pipeline valid bits and
//   restores register defaults; requests are accepted the cycle after.
// ----------------------------------------------------------------------------
module multi_button_mask_debouncer #(
   parameter int unsigned NUM_BUTTONS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [7:0]                        req_pin_levels,
   input  logic [7:0]                        req_button,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_flag_value,
   output logic [15:0]                       rsp_held_ticks,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mbmd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mbmd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // Configuration registers
   logic [7:0] history_mask_ff, history_mask_in;
   logic [7:0] ticks_per_sample_ff, ticks_per_sample_in;
   logic [7:0] active_low_mask_ff, active_low_mask_in;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   mbmd_pkg::action_type in_action_ff, in_action_in;
   logic [7:0]           in_pins_ff, in_pins_in;
   logic [7:0]           in_button_ff, in_button_in;

   // Prescaler
   logic [7:0] prescale_ff, prescale_in;
   logic [7:0] prescale_next;
   logic       sample_pass;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_flag_ff, rsp_flag_in;
   logic [15:0] rsp_held_ff, rsp_held_in;

   // Stage control
   logic                   out_free;
   logic                   stage_fire;
   logic                   is_tick;
   logic                   sample_en;
   logic                   button_in_range;
   logic                   csr_write;
   logic [1:0]             csr_index;
   logic [NUM_BUTTONS-1:0] hit;
   logic [NUM_BUTTONS-1:0] clr_press;
   logic [NUM_BUTTONS-1:0] clr_release;
   logic                   query_flag;
   logic [15:0]            query_held;

   mbmd_pkg::btn_ctl_type  btn_ctl  [NUM_BUTTONS];
   mbmd_pkg::btn_stat_type btn_stat [NUM_BUTTONS];

   // Register port decode
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      history_mask_in     = history_mask_ff;
      ticks_per_sample_in = ticks_per_sample_ff;
      active_low_mask_in  = active_low_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            mbmd_pkg::REG_HISTORY_MASK:     history_mask_in     = csr_pwdata[7:0];
            mbmd_pkg::REG_TICKS_PER_SAMPLE: ticks_per_sample_in = csr_pwdata[7:0];
            mbmd_pkg::REG_ACTIVE_LOW_MASK:  active_low_mask_in  = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mbmd_pkg::REG_HISTORY_MASK:
            csr_prdata = {{(mbmd_pkg::CSR_DATA_W-8){1'b0}}, history_mask_ff};
         mbmd_pkg::REG_TICKS_PER_SAMPLE:
            csr_prdata = {{(mbmd_pkg::CSR_DATA_W-8){1'b0}}, ticks_per_sample_ff};
         mbmd_pkg::REG_ACTIVE_LOW_MASK:
            csr_prdata = {{(mbmd_pkg::CSR_DATA_W-8){1'b0}}, active_low_mask_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Advance a tick, or a query into a free response slot; accept if empty or advancing
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_tick    = (in_action_ff == mbmd_pkg::ACT_TICK);
   assign stage_fire = in_valid_ff && (is_tick || out_free);
   assign req_ready  = !in_valid_ff || stage_fire;

   // Load the input register
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_action_in = in_action_ff;
      in_pins_in   = in_pins_ff;
      in_button_in = in_button_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_action_in = mbmd_pkg::action_type'(req_action);
         in_pins_in   = req_pin_levels;
         in_button_in = req_button;
      end
   end

   // Prescaler: pass the tick once the count reaches the register
   assign prescale_next = prescale_ff + 8'd1;
   assign sample_pass   = (prescale_next >= ticks_per_sample_ff);
   assign sample_en     = stage_fire && is_tick && sample_pass;

   always_comb begin
      prescale_in = prescale_ff;
      if (stage_fire && is_tick) begin
         prescale_in = sample_pass ? 8'd0 : prescale_next;
      end
   end

   // Select the queried button
   assign button_in_range = (in_button_ff < 8'(NUM_BUTTONS));

   for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
      logic level;

      if (gi < mbmd_pkg::PIN_COUNT) begin : g_pin
         assign level = in_pins_ff[gi] ^ active_low_mask_ff[gi];
      end else begin : g_nopin
         assign level = 1'b0;
      end

      assign hit[gi]         = (in_button_ff == 8'(gi));
      assign clr_press[gi]   = stage_fire && hit[gi] &&
                               (in_action_ff == mbmd_pkg::ACT_TAKE_PRESS);
      assign clr_release[gi] = stage_fire && hit[gi] &&
                               (in_action_ff == mbmd_pkg::ACT_TAKE_RELEASE);

      always_comb begin
         btn_ctl[gi].sample      = sample_en;
         btn_ctl[gi].level       = level;
         btn_ctl[gi].clr_press   = clr_press[gi];
         btn_ctl[gi].clr_release = clr_release[gi];
      end

      mbmd_button u_button (
         .clock        (clock),
         .reset        (reset),
         .ctl          (btn_ctl[gi]),
         .history_mask (history_mask_ff),
         .stat         (btn_stat[gi])
      );
   end

   // Build the query answer; no hit leaves zeros for an out-of-range index
   always_comb begin
      query_flag = 1'b0;
      query_held = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (hit[i]) begin
            case (in_action_ff)
               mbmd_pkg::ACT_TAKE_PRESS:   query_flag = btn_stat[i].press_pending;
               mbmd_pkg::ACT_TAKE_RELEASE: query_flag = btn_stat[i].release_pending;
               mbmd_pkg::ACT_READ_STATE: begin
                  query_flag = btn_stat[i].down;
                  query_held = btn_stat[i].hold_count;
               end
               default: ;
            endcase
         end
      end
   end

   // Load or drain the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_held_in  = rsp_held_ff;
      if (stage_fire && !is_tick) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = query_flag;
         rsp_held_in  = query_held;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         history_mask_ff     <= mbmd_pkg::HISTORY_MASK_RST;
         ticks_per_sample_ff <= mbmd_pkg::TICKS_PER_SAMPLE_RST;
         active_low_mask_ff  <= mbmd_pkg::ACTIVE_LOW_MASK_RST;
         in_valid_ff         <= 1'b0;
         prescale_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         history_mask_ff     <= history_mask_in;
         ticks_per_sample_ff <= ticks_per_sample_in;
         active_low_mask_ff  <= active_low_mask_in;
         in_valid_ff         <= in_valid_in;
         prescale_ff         <= prescale_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      in_action_ff <= in_action_in;
      in_pins_ff   <= in_pins_in;
      in_button_ff <= in_button_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_held_ff  <= rsp_held_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flag_value = rsp_flag_ff;
   assign rsp_held_ticks = rsp_held_ff;

`ifndef SYNTHESIS
   // A query leaving the stage always lands in the response register
   a_query_lands: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && !is_tick) |=> rsp_valid_ff)
      else $error("query left the stage without a response");

   // A sampled tick restarts the prescaler
   a_prescale_restart: assert property (@(posedge clock) disable iff (reset)
      sample_en |=> (prescale_ff == 8'd0))
      else $error("prescaler did not restart after a sample");

   // An out-of-range query answers zero
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && !is_tick && !button_in_range) |=>
         (!rsp_flag_ff && (rsp_held_ff == 16'd0)))
      else $error("out-of-range query returned nonzero data");

   // Sampling and flag clearing never coincide
   a_no_sample_clear: assert property (@(posedge clock) disable iff (reset)
      !(sample_en && ((|clr_press) || (|clr_release))))
      else $error("sample and flag clear in the same cycle");
`endif

endmodule
